FILE: design/bfer_pkg.sv
// ----------------------------------------------------------------------------
// bfer_pkg
// Shared widths, register indexes, defaults and divider request types of the
// clamp-to-edge box filter.
// ----------------------------------------------------------------------------
package bfer_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int HM_W      = 24;   // horizontal mean, 8 fraction bits
   localparam int DIV_W     = 32;
   localparam int DEN_W     = 16;

   localparam int CFG_W     = 11;
   localparam int CFG_IDX_W = 2;

   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 2'd0;
   localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 2'd1;
   localparam logic [CFG_IDX_W-1:0] REG_HALF_WIN_X = 2'd2;
   localparam logic [CFG_IDX_W-1:0] REG_HALF_WIN_Y = 2'd3;

   localparam logic [CFG_W-1:0] RST_IMAGE_COLS = 11'd1024;
   localparam logic [CFG_W-1:0] RST_IMAGE_ROWS = 11'd1024;
   localparam logic [CFG_W-1:0] RST_HALF_WIN_X = 11'd1;
   localparam logic [CFG_W-1:0] RST_HALF_WIN_Y = 11'd1;

   localparam int DEF_MAX_COLS       = 1024;
   localparam int DEF_MAX_ROWS       = 1024;
   localparam int DEF_MAX_HALF_WIN_X = 16;
   localparam int DEF_MAX_HALF_WIN_Y = 16;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam logic signed [DIV_W-1:0] SAT_HI = DIV_W'(2**(SAMPLE_W-1) - 1);
   localparam logic signed [DIV_W-1:0] SAT_LO = -SAT_HI - DIV_W'(1);

   typedef struct packed {
      logic             start;
      logic             neg;
      logic [DIV_W-1:0] mag;
      logic [DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic                    done;
      logic signed [DIV_W-1:0] quo;
   } div_rsp_type;

endpackage

FILE: design/box_filter_2d_edge_replicate_unit.sv
// ----------------------------------------------------------------------------
// box_filter_2d_edge_replicate_unit
// Streaming separable box mean with edge replication over a raster frame.
// ----------------------------------------------------------------------------
// Channel  Ports     tdata                 tuser / tlast
// req      req_*     sample[15:0]          tuser: req_type
// rsp      rsp_*     mean_value[15:0]      tlast: frame_last
// csr      csr_*     csr_wdata: register value, csr_index: register
//
// One request at a time, all work goes through the row window and line RAMs
// (registered read) and one shared divider.
// Pixel: writes n horizontal means (0 before column hx, else 1, or
// min(hx+1, cols) at row end), then may release a result. Drain: releases a
// result only once all pixels of the frame are in and one is still owed.
// No clearing pass after reset. rsp holds in its output register under stall;
// the next request is taken while it waits, a further result waits for it.
// ----------------------------------------------------------------------------
module box_filter_2d_edge_replicate_unit #(
   parameter int MAX_COLS       = bfer_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS       = bfer_pkg::DEF_MAX_ROWS,
   parameter int MAX_HALF_WIN_X = bfer_pkg::DEF_MAX_HALF_WIN_X,
   parameter int MAX_HALF_WIN_Y = bfer_pkg::DEF_MAX_HALF_WIN_Y
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bfer_pkg::SAMPLE_W-1:0]     req_tdata,   // sample
   input  logic                              req_tuser,   // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bfer_pkg::SAMPLE_W-1:0]     rsp_tdata,   // mean_value
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [bfer_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [bfer_pkg::CFG_W-1:0]        csr_wdata
);

   localparam int SAMPLE_W  = bfer_pkg::SAMPLE_W;
   localparam int HM_W      = bfer_pkg::HM_W;
   localparam int DIV_W     = bfer_pkg::DIV_W;
   localparam int DEN_W     = bfer_pkg::DEN_W;
   localparam int CFG_W     = bfer_pkg::CFG_W;
   localparam int HWIN_W    = 5;
   localparam int CI_W      = $clog2(MAX_COLS);
   localparam int CC_W      = $clog2(MAX_COLS + 1);
   localparam int RI_W      = $clog2(MAX_ROWS);
   localparam int RC_W      = $clog2(MAX_ROWS + 1);
   localparam int HX_W      = $clog2(MAX_HALF_WIN_X + 1);
   localparam int HY_W      = $clog2(MAX_HALF_WIN_Y + 1);
   localparam int ROW_RING  = 2 * MAX_HALF_WIN_X + 1;
   localparam int RR_W      = $clog2(ROW_RING);
   localparam int LINE_RING = 2 * MAX_HALF_WIN_Y + MAX_HALF_WIN_X + 1;
   localparam int LR_W      = $clog2(LINE_RING);
   localparam int HA_W      = LR_W + CI_W;
   localparam int HML_DEPTH = LINE_RING * (2 ** CI_W);
   localparam int MAX_HW    = (MAX_HALF_WIN_X > MAX_HALF_WIN_Y) ?
                              MAX_HALF_WIN_X : MAX_HALF_WIN_Y;
   localparam int K_W       = $clog2(2 * MAX_HW + 1);
   localparam int CNT_W     = $clog2(MAX_COLS * MAX_ROWS +
                              MAX_HALF_WIN_Y * MAX_COLS + MAX_HALF_WIN_X + 1);
   localparam int HSUM_W    = SAMPLE_W + $clog2(ROW_RING);
   localparam int VSUM_W    = HM_W + $clog2(2 * MAX_HALF_WIN_Y + 1);
   localparam int ACC_W     = (HSUM_W > VSUM_W) ? HSUM_W : VSUM_W;
   localparam int PW        = ((CI_W > K_W) ? CI_W : K_W) + 2;
   localparam int QW        = ((RI_W > K_W) ? RI_W : K_W) + 2;
   localparam int LW        = ((LR_W > QW) ? LR_W : QW) + 2;
   localparam int ST_W      = 4;

   localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] ST_DECIDE = 4'd1;
   localparam logic [ST_W-1:0] ST_HRD    = 4'd2;
   localparam logic [ST_W-1:0] ST_HWAIT  = 4'd3;
   localparam logic [ST_W-1:0] ST_HDIV   = 4'd4;
   localparam logic [ST_W-1:0] ST_POST   = 4'd5;
   localparam logic [ST_W-1:0] ST_VRD    = 4'd6;
   localparam logic [ST_W-1:0] ST_VWAIT  = 4'd7;
   localparam logic [ST_W-1:0] ST_VDIV   = 4'd8;
   localparam logic [ST_W-1:0] ST_OUT    = 4'd9;

   // configuration
   logic [CFG_W-1:0] cols_ff, cols_in, rows_ff, rows_in, hx_ff, hx_in, hy_ff, hy_in;
   logic [CC_W-1:0]  cols_c;
   logic [RC_W-1:0]  rows_c;
   logic [HX_W-1:0]  hx_c;
   logic [HY_W-1:0]  hy_c;
   logic [CI_W-1:0]  col_last;
   logic [RI_W-1:0]  row_last;
   logic [CNT_W-1:0] total_ff, lat_ff;
   logic [K_W-1:0]   hx2, hy2;

   // sequencer
   logic [ST_W-1:0]     state_ff, state_in;
   logic                kind_ff, kind_in;
   logic [SAMPLE_W-1:0] samp_ff, samp_in;
   logic [CI_W-1:0]     j_ff, j_in, hcol_ff, hcol_in, hi_ff, hi_in;
   logic [RR_W-1:0]     jmod_ff, jmod_in;
   logic [LR_W-1:0]     in_line_ff, in_line_in, oline_ff, oline_in;
   logic [CNT_W-1:0]    in_cnt_ff, in_cnt_in, out_cnt_ff, out_cnt_in;
   logic [CI_W-1:0]     ocol_ff, ocol_in;
   logic [RI_W-1:0]     orow_ff, orow_in;
   logic [K_W-1:0]      kcnt_ff, kcnt_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                rdh_ff, rdh_in, rdv_ff, rdv_in;
   logic                div_go_ff, div_go_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                frame_clr;

   // addressing
   logic signed [PW-1:0] hpos;
   logic [CI_W-1:0]      hp;
   logic [RR_W-1:0]      hdist;
   logic [RR_W-1:0]      rw_idx;
   logic signed [QW-1:0] vpos, vdelta;
   logic [RI_W-1:0]      vrow;
   logic signed [LW-1:0] lsum;
   logic [LR_W-1:0]      vline;
   logic [HA_W-1:0]      hml_raddr;
   logic                 rw_we, hml_we;

   // memories
   logic [SAMPLE_W-1:0] rw_mem [ROW_RING];
   logic [SAMPLE_W-1:0] rw_q_ff;
   logic [HM_W-1:0]     hml_mem [HML_DEPTH];
   logic [HM_W-1:0]     hml_q_ff;

   // divider
   bfer_pkg::div_req_type div_req;
   bfer_pkg::div_rsp_type div_rsp;
   logic [ACC_W-1:0]      acc_mag;
   logic signed [DIV_W-1:0] q;

   always_comb begin
      if (cols_ff == '0)
         cols_c = CC_W'(1);
      else if (32'(cols_ff) > MAX_COLS)
         cols_c = CC_W'(MAX_COLS);
      else
         cols_c = CC_W'(cols_ff);
      if (rows_ff == '0)
         rows_c = RC_W'(1);
      else if (32'(rows_ff) > MAX_ROWS)
         rows_c = RC_W'(MAX_ROWS);
      else
         rows_c = RC_W'(rows_ff);
      hx_c     = (32'(hx_ff) > MAX_HALF_WIN_X) ? HX_W'(MAX_HALF_WIN_X) : HX_W'(hx_ff);
      hy_c     = (32'(hy_ff) > MAX_HALF_WIN_Y) ? HY_W'(MAX_HALF_WIN_Y) : HY_W'(hy_ff);
      col_last = CI_W'(cols_c - CC_W'(1));
      row_last = RI_W'(rows_c - RC_W'(1));
      hx2      = K_W'({hx_c, 1'b0});
      hy2      = K_W'({hy_c, 1'b0});
   end

   // horizontal window: ring slot of the clamped column
   always_comb begin
      hpos = $signed(PW'(hcol_ff)) + $signed(PW'(kcnt_ff)) - $signed(PW'(hx_c));
      if (hpos < 0)
         hp = '0;
      else if (hpos > $signed(PW'(col_last)))
         hp = col_last;
      else
         hp = CI_W'(hpos);
      hdist = RR_W'(j_ff - hp);
      if (jmod_ff >= hdist)
         rw_idx = jmod_ff - hdist;
      else
         rw_idx = RR_W'((RR_W+1)'(jmod_ff) + (RR_W+1)'(ROW_RING) - (RR_W+1)'(hdist));
   end

   // vertical window: line slot of the clamped row
   always_comb begin
      vpos = $signed(QW'(orow_ff)) + $signed(QW'(kcnt_ff)) - $signed(QW'(hy_c));
      if (vpos < 0)
         vrow = '0;
      else if (vpos > $signed(QW'(row_last)))
         vrow = row_last;
      else
         vrow = RI_W'(vpos);
      vdelta = $signed(QW'(vrow)) - $signed(QW'(orow_ff));
      lsum   = $signed(LW'(oline_ff)) + LW'(vdelta);
      if (lsum < 0)
         vline = LR_W'(lsum + LW'(LINE_RING));
      else if (lsum >= $signed(LW'(LINE_RING)))
         vline = LR_W'(lsum - LW'(LINE_RING));
      else
         vline = LR_W'(lsum);
      hml_raddr = {vline, ocol_ff};
   end

   always_comb begin
      acc_mag        = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
      div_req.start  = div_go_ff;
      div_req.neg    = acc_ff[ACC_W-1];
      if (state_ff == ST_HDIV) begin
         div_req.mag = DIV_W'(acc_mag) << 8;
         div_req.den = DEN_W'({hx_c, 1'b1});
      end else begin
         div_req.mag = DIV_W'(acc_mag);
         div_req.den = DEN_W'({hy_c, 1'b1}) << 8;
      end
      q = div_rsp.quo;
   end

   bfer_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      samp_in      = samp_ff;
      j_in         = j_ff;
      jmod_in      = jmod_ff;
      in_line_in   = in_line_ff;
      in_cnt_in    = in_cnt_ff;
      hcol_in      = hcol_ff;
      hi_in        = hi_ff;
      out_cnt_in   = out_cnt_ff;
      ocol_in      = ocol_ff;
      orow_in      = orow_ff;
      oline_in     = oline_ff;
      kcnt_in      = kcnt_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      cols_in      = cols_ff;
      rows_in      = rows_ff;
      hx_in        = hx_ff;
      hy_in        = hy_ff;
      rdh_in       = (state_ff == ST_HRD);
      rdv_in       = (state_ff == ST_VRD);
      div_go_in    = 1'b0;
      rw_we        = 1'b0;
      hml_we       = 1'b0;
      frame_clr    = 1'b0;

      acc_in = acc_ff;
      if (rdh_ff)
         acc_in = acc_ff + {{(ACC_W-SAMPLE_W){rw_q_ff[SAMPLE_W-1]}}, rw_q_ff};
      else if (rdv_ff)
         acc_in = acc_ff + {{(ACC_W-HM_W){hml_q_ff[HM_W-1]}}, hml_q_ff};

      if (rsp_tready)
         rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               samp_in  = req_tdata;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            kcnt_in = '0;
            acc_in  = '0;
            if (kind_ff == bfer_pkg::REQ_PIXEL) begin
               if (in_cnt_ff >= total_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  rw_we = 1'b1;
                  if (32'(j_ff) >= 32'(hx_c) || j_ff == col_last) begin
                     hcol_in  = (32'(j_ff) >= 32'(hx_c)) ? j_ff - CI_W'(hx_c) : '0;
                     hi_in    = (j_ff == col_last) ? col_last : j_ff - CI_W'(hx_c);
                     state_in = ST_HRD;
                  end else begin
                     state_in = ST_POST;
                  end
               end
            end else begin
               if (in_cnt_ff < total_ff || out_cnt_ff >= total_ff)
                  state_in = ST_IDLE;
               else
                  state_in = ST_VRD;
            end
         end
         ST_HRD: begin
            if (kcnt_ff == hx2)
               state_in = ST_HWAIT;
            else
               kcnt_in = kcnt_ff + K_W'(1);
         end
         ST_HWAIT: begin
            div_go_in = 1'b1;
            state_in  = ST_HDIV;
         end
         ST_HDIV: begin
            if (div_rsp.done) begin
               hml_we = 1'b1;
               if (hcol_ff == hi_ff) begin
                  state_in = ST_POST;
               end else begin
                  hcol_in  = hcol_ff + CI_W'(1);
                  kcnt_in  = '0;
                  acc_in   = '0;
                  state_in = ST_HRD;
               end
            end
         end
         ST_POST: begin
            in_cnt_in = in_cnt_ff + CNT_W'(1);
            if (j_ff == col_last) begin
               j_in       = '0;
               jmod_in    = '0;
               in_line_in = (in_line_ff == LR_W'(LINE_RING - 1)) ? '0 : in_line_ff + LR_W'(1);
            end else begin
               j_in    = j_ff + CI_W'(1);
               jmod_in = (jmod_ff == RR_W'(ROW_RING - 1)) ? '0 : jmod_ff + RR_W'(1);
            end
            kcnt_in = '0;
            acc_in  = '0;
            if (in_cnt_ff < lat_ff || out_cnt_ff >= total_ff)
               state_in = ST_IDLE;
            else
               state_in = ST_VRD;
         end
         ST_VRD: begin
            if (kcnt_ff == hy2)
               state_in = ST_VWAIT;
            else
               kcnt_in = kcnt_ff + K_W'(1);
         end
         ST_VWAIT: begin
            div_go_in = 1'b1;
            state_in  = ST_VDIV;
         end
         ST_VDIV: begin
            if (div_rsp.done) begin
               if (q > bfer_pkg::SAT_HI)
                  mean_in = SAMPLE_W'(bfer_pkg::SAT_HI);
               else if (q < bfer_pkg::SAT_LO)
                  mean_in = SAMPLE_W'(bfer_pkg::SAT_LO);
               else
                  mean_in = SAMPLE_W'(q);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mean_ff;
               rsp_last_in  = (out_cnt_ff + CNT_W'(1) == total_ff);
               out_cnt_in   = out_cnt_ff + CNT_W'(1);
               if (ocol_ff == col_last) begin
                  ocol_in  = '0;
                  orow_in  = orow_ff + RI_W'(1);
                  oline_in = (oline_ff == LR_W'(LINE_RING - 1)) ? '0 : oline_ff + LR_W'(1);
               end else begin
                  ocol_in = ocol_ff + CI_W'(1);
               end
               if (out_cnt_ff + CNT_W'(1) == total_ff)
                  frame_clr = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         frame_clr = 1'b1;
         case (csr_index)
            bfer_pkg::REG_IMAGE_COLS: cols_in = csr_wdata;
            bfer_pkg::REG_IMAGE_ROWS: rows_in = csr_wdata;
            bfer_pkg::REG_HALF_WIN_X: hx_in   = CFG_W'(csr_wdata[HWIN_W-1:0]);
            bfer_pkg::REG_HALF_WIN_Y: hy_in   = CFG_W'(csr_wdata[HWIN_W-1:0]);
            default: frame_clr = 1'b0;
         endcase
      end

      if (frame_clr) begin
         in_cnt_in  = '0;
         out_cnt_in = '0;
         j_in       = '0;
         jmod_in    = '0;
         in_line_in = '0;
         ocol_in    = '0;
         orow_in    = '0;
         oline_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rdh_ff       <= 1'b0;
         rdv_ff       <= 1'b0;
         div_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         in_cnt_ff    <= '0;
         out_cnt_ff   <= '0;
         j_ff         <= '0;
         jmod_ff      <= '0;
         in_line_ff   <= '0;
         ocol_ff      <= '0;
         orow_ff      <= '0;
         oline_ff     <= '0;
         cols_ff      <= bfer_pkg::RST_IMAGE_COLS;
         rows_ff      <= bfer_pkg::RST_IMAGE_ROWS;
         hx_ff        <= bfer_pkg::RST_HALF_WIN_X;
         hy_ff        <= bfer_pkg::RST_HALF_WIN_Y;
      end else begin
         state_ff     <= state_in;
         rdh_ff       <= rdh_in;
         rdv_ff       <= rdv_in;
         div_go_ff    <= div_go_in;
         rsp_valid_ff <= rsp_valid_in;
         in_cnt_ff    <= in_cnt_in;
         out_cnt_ff   <= out_cnt_in;
         j_ff         <= j_in;
         jmod_ff      <= jmod_in;
         in_line_ff   <= in_line_in;
         ocol_ff      <= ocol_in;
         orow_ff      <= orow_in;
         oline_ff     <= oline_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         hx_ff        <= hx_in;
         hy_ff        <= hy_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      samp_ff     <= samp_in;
      hcol_ff     <= hcol_in;
      hi_ff       <= hi_in;
      kcnt_ff     <= kcnt_in;
      acc_ff      <= acc_in;
      mean_ff     <= mean_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      total_ff    <= CNT_W'(cols_c) * CNT_W'(rows_c);
      lat_ff      <= CNT_W'(hy_c) * CNT_W'(cols_c) + CNT_W'(hx_c);
   end

   always_ff @(posedge clock) begin
      if (rw_we)
         rw_mem[jmod_ff] <= samp_ff;
      rw_q_ff <= rw_mem[rw_idx];
   end

   always_ff @(posedge clock) begin
      if (hml_we)
         hml_mem[{in_line_ff, hcol_ff}] <= q[HM_W-1:0];
      hml_q_ff <= hml_mem[hml_raddr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: design/bfer_div.sv
// ----------------------------------------------------------------------------
// bfer_div
// Radix-2 restoring divider, rounds to nearest with ties away from zero.
// ----------------------------------------------------------------------------
module bfer_div (
   input  logic                 clock,
   input  logic                 reset,
   input  bfer_pkg::div_req_type req,
   output bfer_pkg::div_rsp_type rsp
);

   localparam int DIV_W = bfer_pkg::DIV_W;
   localparam int DEN_W = bfer_pkg::DEN_W;
   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      diff    = trial - {1'b0, den_ff};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         quo_in  = req.mag + DIV_W'(req.den >> 1);
         rem_in  = '0;
         den_in  = req.den;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = neg_ff ? -$signed(quo_ff) : $signed(quo_ff);

endmodule

FILE: design/bfer_chk.sv
// ----------------------------------------------------------------------------
// bfer_chk
// Port-level checks of the box filter, bound to the top level.
// ----------------------------------------------------------------------------
module bfer_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [bfer_pkg::SAMPLE_W-1:0] rsp_tdata,
   input logic                          rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_rst_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while first in work");

   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result right after request");

endmodule

bind box_filter_2d_edge_replicate_unit bfer_chk u_bfer_chk (.*);
